@@ hw/rtl/rhd_pkg.sv @@
// Shared types and constants for the RLP header decoder.
`default_nettype none

package rhd_pkg;

  localparam logic [7:0] PFX_STR        = 8'h80;
  localparam logic [7:0] PFX_STR_SHORT  = 8'hB7;
  localparam logic [7:0] PFX_LIST       = 8'hC0;
  localparam logic [7:0] PFX_LIST_SHORT = 8'hF7;
  localparam logic [63:0] LONG_MIN_LEN  = 64'd56;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_NONCANON = 3'd2;
  localparam logic [2:0] ERR_LEAD0    = 3'd3;
  localparam logic [2:0] ERR_LIST     = 3'd4;
  localparam logic [2:0] ERR_LONG     = 3'd5;

  localparam logic CFG_STRING_ONLY    = 1'b0;
  localparam logic CFG_ALLOW_LEFTOVER = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PEEK = 3'b010,
    PH_LEN  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [31:0] bytes_left;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [3:0]  header_length;
    logic [31:0] body_len;
    logic        is_list;
  } res_t;

  typedef struct packed {
    logic string_only;
    logic allow_leftover;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/rhd_core.sv @@
// Header decode state and per-byte next-state / result logic.
`default_nettype none

module rhd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  rhd_pkg::in_word_t in_word,
  input  rhd_pkg::cfg_t   cfg,
  output logic            emit,
  output rhd_pkg::res_t   res
);
  import rhd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  lbl_r, lbl_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] ah_r, ah_nxt;
  logic        list_r, list_nxt;
  logic [3:0]  cons_r, cons_nxt;

  logic [7:0]  b;
  logic [31:0] left;
  logic [31:0] rem;
  logic [63:0] acc_sh;
  logic [3:0]  lbl_dec;
  logic [3:0]  lol;
  logic        pfx_list;
  logic [7:0]  short_len;

  function automatic res_t mk(input logic lst, input logic [31:0] plen,
                              input logic [3:0] hlen, input logic [2:0] e);
    res_t r;
    r.is_list       = (e == ERR_OK) ? lst  : 1'b0;
    r.body_len      = (e == ERR_OK) ? plen : 32'd0;
    r.header_length = (e == ERR_OK) ? hlen : 4'd0;
    r.error_code    = e;
    return r;
  endfunction

  function automatic res_t fin(input logic lst, input logic [63:0] plen,
                               input logic [3:0] hlen, input logic [31:0] remaining,
                               input cfg_t c);
    logic [2:0] e;
    if ({32'd0, remaining} < plen) e = ERR_SHORT;
    else if (lst && c.string_only) e = ERR_LIST;
    else if (!c.allow_leftover && ({32'd0, remaining} != plen)) e = ERR_LONG;
    else e = ERR_OK;
    return mk(lst, plen[31:0], hlen, e);
  endfunction

  assign b         = in_word.data_byte;
  assign left      = in_word.bytes_left;
  assign rem       = left - 32'd1;
  assign acc_sh    = {acc_r[55:0], b};
  assign lbl_dec   = lbl_r - 4'd1;
  assign lol       = {1'b0, b[2:0]} + 4'd1;
  assign pfx_list  = (b >= PFX_LIST);
  assign short_len = pfx_list ? (b - PFX_LIST) : (b - PFX_STR);

  always_comb begin
    emit      = 1'b0;
    res       = '0;
    phase_nxt = phase_r;
    lbl_nxt   = lbl_r;
    acc_nxt   = acc_r;
    ah_nxt    = ah_r;
    list_nxt  = list_r;
    cons_nxt  = cons_r;
    case (phase_r)
      PH_PEEK: begin
        emit = 1'b1;
        if (b < PFX_STR) res = mk(1'b0, 32'd0, 4'd0, ERR_NONCANON);
        else res = fin(1'b0, 64'd1, 4'd1, ah_r, cfg);
      end
      PH_LEN: begin
        if (cons_r == 4'd1 && b == 8'd0) begin
          emit = 1'b1;
          res  = mk(1'b0, 32'd0, 4'd0, ERR_LEAD0);
        end else begin
          acc_nxt  = acc_sh;
          cons_nxt = cons_r + 4'd1;
          ah_nxt   = ah_r - 32'd1;
          lbl_nxt  = lbl_dec;
          if (lbl_dec == 4'd0) begin
            emit = 1'b1;
            if (acc_sh < LONG_MIN_LEN) res = mk(1'b0, 32'd0, 4'd0, ERR_NONCANON);
            else res = fin(list_r, acc_sh, cons_r + 4'd1, ah_r - 32'd1, cfg);
          end
        end
      end
      PH_IDLE: begin
        if (left == 32'd0) begin
          emit = 1'b1;
          res  = mk(1'b0, 32'd0, 4'd0, ERR_SHORT);
        end else if (b < PFX_STR) begin
          emit = 1'b1;
          res  = fin(1'b0, 64'd1, 4'd0, left, cfg);
        end else if (b inside {[PFX_STR:PFX_STR_SHORT], [PFX_LIST:PFX_LIST_SHORT]}) begin
          if (!pfx_list && short_len == 8'd1) begin
            if (rem == 32'd0) begin
              emit = 1'b1;
              res  = mk(1'b0, 32'd0, 4'd0, ERR_SHORT);
            end else begin
              phase_nxt = PH_PEEK;
              ah_nxt    = rem;
              cons_nxt  = 4'd1;
            end
          end else begin
            emit = 1'b1;
            res  = fin(pfx_list, {56'd0, short_len}, 4'd1, rem, cfg);
          end
        end else begin
          if (rem < {28'd0, lol}) begin
            emit = 1'b1;
            res  = mk(1'b0, 32'd0, 4'd0, ERR_SHORT);
          end else begin
            phase_nxt = PH_LEN;
            lbl_nxt   = lol;
            acc_nxt   = 64'd0;
            ah_nxt    = rem;
            list_nxt  = pfx_list;
            cons_nxt  = 4'd1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (emit) begin
      phase_nxt = PH_IDLE;
      lbl_nxt   = 4'd0;
      acc_nxt   = 64'd0;
      ah_nxt    = 32'd0;
      list_nxt  = 1'b0;
      cons_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      lbl_r   <= 4'd0;
      acc_r   <= 64'd0;
      ah_r    <= 32'd0;
      list_r  <= 1'b0;
      cons_r  <= 4'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      lbl_r   <= lbl_nxt;
      acc_r   <= acc_nxt;
      ah_r    <= ah_nxt;
      list_r  <= list_nxt;
      cons_r  <= cons_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rlp_header_decoder.sv @@
// Top level of the RLP header decoder: input register, decode core, result register.
//
// channel | dir | width | contents
// in_     | in  | 40    | data_byte, bytes_left; one word per header byte
// out_    | out | 40    | is_list, body_len, header_length, error_code
// cfg_    | in  | 1     | index 0 string_only, index 1 allow_leftover
//
// One word per cycle unless held up as below; each result is registered as its last word decodes.
// The decode state updates once per word, in the cycle the word leaves the input register.
// A word that settles a header waits in the input register while the result register is
// full and not taken; words that give no result pass regardless.
// Synchronous active-low reset returns to awaiting a prefix; no clearing pass.
`default_nettype none

module rlp_header_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] data_byte, [39:8] bytes_left
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] is_list, [32:1] body_len,
                                  // [36:33] header_length, [39:37] error_code
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);
  import rhd_pkg::*;

  logic     in_vld_r;
  in_word_t in_word_r;
  cfg_t     cfg_r;
  logic     out_vld_r;
  res_t     out_res_r;
  logic     emit;
  res_t     res;
  logic     step;

  assign step      = in_vld_r && (!emit || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_word_r <= in_word_t'(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.string_only    <= 1'b1;
      cfg_r.allow_leftover <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STRING_ONLY:    cfg_r.string_only    <= cfg_wdata;
        CFG_ALLOW_LEFTOVER: cfg_r.allow_leftover <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rhd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_word_r),
    .cfg     (cfg_r),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.error_code != ERR_OK |->
      !out_res_r.is_list && out_res_r.body_len == 32'd0 &&
      out_res_r.header_length == 4'd0)
    else $error("error result carries nonzero fields");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_res_r.error_code <= ERR_LONG && out_res_r.header_length <= 4'd9)
    else $error("result code or header length out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !step |-> out_vld_r && !out_tready && emit)
    else $error("input stalled without a blocked result");

  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.error_code == ERR_OK && out_res_r.header_length == 4'd0 |->
      out_res_r.body_len == 32'd1 && !out_res_r.is_list)
    else $error("single byte result with wrong payload");

endmodule

`default_nettype wire
